/* design/frame_overrun_monitor_macros.svh */
// ============================================================================
// frame_overrun_monitor_macros
// Assertion macros shared by the frame overrun monitor RTL.
// ============================================================================
`ifndef FRAME_OVERRUN_MONITOR_MACROS_SVH
`define FRAME_OVERRUN_MONITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FOM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame_overrun_monitor: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define FOM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame_overrun_monitor: assertion failed");

`endif

/* design/fom_pkg.sv */
// ============================================================================
// fom_pkg
// Types, codes and default widths for the frame overrun monitor.
// ============================================================================
`timescale 1ns / 1ps

package fom_pkg;

    // Default widths of the internal counters
    localparam int CYCLE_BITS_DEF   = 32;
    localparam int OVERRUN_BITS_DEF = 16;

    // Fixed port field widths
    localparam int CYC_W    = 32;
    localparam int OVR_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    // Commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_RESUME = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // Real-time modes
    localparam logic [2:0] RT_HARD_TICK   = 3'd0;
    localparam logic [2:0] RT_HARD_PERIOD = 3'd1;
    localparam logic [2:0] RT_SOFT_LAG    = 3'd2;
    localparam logic [2:0] RT_LOG_ONLY    = 3'd3;
    localparam logic [2:0] RT_SKIP_BUSY   = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RT_MODE       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAG       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_ON_CYCLE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CYCLE  = 4'd3;

    typedef struct packed {
        logic [1:0]       command;
        logic             step_unconsumed;
        logic             pool_running;
        logic             period_miss;
        logic [CYC_W-1:0] task_cycles;
        logic             pause_request;
    } t_fom_in;

    typedef struct packed {
        logic             tick_sent;
        logic [CYC_W-1:0] cycle_count;
        logic             hard_fail;
        logic             stopped;
        logic             paused;
        logic             lag_over;
        logic             lag_record;
        logic [CYC_W-1:0] worst_lag;
        logic [OVR_W-1:0] overrun_total;
    } t_fom_out;

    typedef struct packed {
        logic [2:0]       rt_mode;
        logic [15:0]      max_lag;
        logic             stop_on_cycle;
        logic [CYC_W-1:0] target_cycle;
    } t_fom_cfg;

endpackage

/* design/fom_if.sv */
// ============================================================================
// fom_if
// Handshake channels of the frame overrun monitor: input, result, config.
// ============================================================================
`timescale 1ns / 1ps

interface fom_in_if;
    import fom_pkg::*;
    logic    valid;
    logic    ready;
    t_fom_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fom_out_if;
    import fom_pkg::*;
    logic     valid;
    logic     ready;
    t_fom_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fom_cfg_if;
    import fom_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* design/fom_cfg_regs.sv */
// ============================================================================
// fom_cfg_regs
// Configuration register file of the frame overrun monitor.
// ============================================================================
`timescale 1ns / 1ps

module fom_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fom_cfg_if.sink           i_cfg,
    output fom_pkg::t_fom_cfg o_cfg
);
    import fom_pkg::*;

    t_fom_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RT_MODE:       r_cfg.rt_mode       <= i_cfg.wdata[2:0];
                REG_MAX_LAG:       r_cfg.max_lag       <= i_cfg.wdata[15:0];
                REG_STOP_ON_CYCLE: r_cfg.stop_on_cycle <= i_cfg.wdata[0];
                REG_TARGET_CYCLE:  r_cfg.target_cycle  <= i_cfg.wdata[CYC_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

endmodule

/* design/frame_overrun_monitor.sv */
// ============================================================================
// frame_overrun_monitor
// Frame tick overrun monitor: lag, violation checks, tick issue, stop/pause.
// ============================================================================
`timescale 1ns / 1ps
// Usage:
//   i_in   : one word per command (frame tick, resume, stop request) plus the
//            task side status sampled for that tick.
//   o_out  : exactly one result word per input word, in order.
//   i_cfg  : register writes (mode, max lag, stop enable, target cycle);
//            always ready; written only while the block is idle, which the block does not enforce.
// Results are registered: a result appears in the cycle after its input word is accepted.
// Throughput: one word per cycle unless stalled. The state update is a single pass of
//   compare/subtract/increment logic from the accepted word into the state
//   and result registers, so the next word sees the new state at once.
// Stall: the result register holds its word until taken; a new input word
//   is accepted in the same cycle the old result leaves, so a stalled
//   receiver backs up i_in.ready and nothing is lost.
// Reset: synchronous, active low. Counters, flags and config clear to zero;
//   the result register empties.
// Once stopped (hard violation, target reached or stop request) every
//   command is ignored and results just report the frozen state.

`include "frame_overrun_monitor_macros.svh"

module frame_overrun_monitor #(
    parameter int CYCLE_BITS   = fom_pkg::CYCLE_BITS_DEF,
    parameter int OVERRUN_BITS = fom_pkg::OVERRUN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fom_in_if.sink    i_in,
    fom_out_if.source o_out,
    fom_cfg_if.sink   i_cfg
);
    import fom_pkg::*;

    // ---------------------------------------------------------------- config
    t_fom_cfg cfg;

    fom_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // ----------------------------------------------------------------- state
    logic [CYCLE_BITS-1:0]   r_issued,  n_issued;
    logic [OVERRUN_BITS-1:0] r_ovr,     n_ovr;
    logic [CYCLE_BITS-1:0]   r_largest, n_largest;
    logic r_lag_flag,   n_lag_flag;
    logic r_pause_flag, n_pause_flag;
    logic r_stop_flag,  n_stop_flag;
    logic r_fail_flag,  n_fail_flag;
    logic n_tick, n_loss;

    logic     r_out_valid;
    t_fom_out r_out;

    logic acc;

    // Output register frees up in the same cycle it is drained
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign acc         = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ---------------------------------------------------------- next state
    // 64-bit scratch words let any counter width up to 64 bits meet the fixed port fields.
    logic [63:0]           w_task;
    logic [CYCLE_BITS-1:0] task_c;
    logic [CYCLE_BITS-1:0] lag;
    logic [63:0]           lag64;
    logic [63:0]           issued64;
    logic                  busy;
    logic                  viol;

    always_comb begin
        n_issued     = r_issued;
        n_ovr        = r_ovr;
        n_largest    = r_largest;
        n_lag_flag   = r_lag_flag;
        n_pause_flag = r_pause_flag;
        n_stop_flag  = r_stop_flag;
        n_fail_flag  = r_fail_flag;
        n_tick       = 1'b0;
        n_loss       = 1'b0;
        viol         = 1'b0;

        w_task = {32'b0, i_in.data.task_cycles};
        task_c = w_task[CYCLE_BITS-1:0];
        busy   = i_in.data.step_unconsumed || i_in.data.pool_running;
        lag    = (r_issued > task_c) ? (r_issued - task_c) : '0;
        lag64  = '0;
        lag64[CYCLE_BITS-1:0] = lag;

        issued64 = '0;
        issued64[CYCLE_BITS-1:0] = r_issued + {{(CYCLE_BITS-1){1'b0}}, 1'b1};

        if (!r_stop_flag) begin
            if (i_in.data.command == CMD_TICK && !r_pause_flag) begin
                case (cfg.rt_mode)
                    RT_HARD_TICK:   viol = busy;
                    RT_HARD_PERIOD: viol = i_in.data.period_miss;
                    RT_SOFT_LAG: begin
                        if (lag64 > {48'b0, cfg.max_lag}) n_lag_flag = 1'b1;
                    end
                    default: ;  // log only, skip on busy and unused codes
                endcase

                // Ratchet worst lag; a lag of one is normal pipelining
                if (lag > r_largest && lag > {{(CYCLE_BITS-1){1'b0}}, 1'b1}) begin
                    n_largest = lag;
                    n_loss    = 1'b1;
                end
                if (busy && r_ovr != '1) n_ovr = r_ovr + {{(OVERRUN_BITS-1){1'b0}}, 1'b1};

                if (viol) begin
                    n_fail_flag = 1'b1;
                    n_stop_flag = 1'b1;
                end else begin
                    n_tick   = 1'b1;
                    n_issued = issued64[CYCLE_BITS-1:0];
                    if (cfg.stop_on_cycle && issued64 >= {32'b0, cfg.target_cycle}) begin
                        n_stop_flag = 1'b1;
                    end else if (i_in.data.pause_request) begin
                        n_pause_flag = 1'b1;
                    end
                end
            end else if (i_in.data.command == CMD_RESUME && r_pause_flag) begin
                n_pause_flag = 1'b0;
                n_ovr        = '0;
            end else if (i_in.data.command == CMD_STOP) begin
                n_stop_flag = 1'b1;
            end
        end
    end

    // --------------------------------------------------------- result word
    logic [63:0] w_issued, w_largest, w_ovr;
    t_fom_out    n_out;

    always_comb begin
        w_issued  = '0;
        w_largest = '0;
        w_ovr     = '0;
        w_issued[CYCLE_BITS-1:0]  = n_issued;
        w_largest[CYCLE_BITS-1:0] = n_largest;
        w_ovr[OVERRUN_BITS-1:0]   = n_ovr;

        n_out.tick_sent     = n_tick;
        n_out.cycle_count   = w_issued[CYC_W-1:0];
        n_out.hard_fail     = n_fail_flag;
        n_out.stopped       = n_stop_flag;
        n_out.paused        = n_pause_flag;
        n_out.lag_over      = n_lag_flag;
        n_out.lag_record    = n_loss;
        n_out.worst_lag     = w_largest[CYC_W-1:0];
        n_out.overrun_total = w_ovr[OVR_W-1:0];
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued     <= '0;
            r_ovr        <= '0;
            r_largest    <= '0;
            r_lag_flag   <= 1'b0;
            r_pause_flag <= 1'b0;
            r_stop_flag  <= 1'b0;
            r_fail_flag  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (acc) begin
                r_issued     <= n_issued;
                r_ovr        <= n_ovr;
                r_largest    <= n_largest;
                r_lag_flag   <= n_lag_flag;
                r_pause_flag <= n_pause_flag;
                r_stop_flag  <= n_stop_flag;
                r_fail_flag  <= n_fail_flag;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_out;
        end
    end

    // ----------------------------------------------------------- assertions
    `FOM_ASSERT_IMP(a_fail_implies_stop, i_clk, i_rst_n, r_fail_flag, r_stop_flag)
    `FOM_ASSERT_NXT(a_stop_sticky, i_clk, i_rst_n, r_stop_flag, r_stop_flag)
    `FOM_ASSERT_NXT(a_issued_only_on_accept, i_clk, i_rst_n, !acc, $stable(r_issued))
    `FOM_ASSERT_NXT(a_accept_loads_result, i_clk, i_rst_n, acc, r_out_valid)

endmodule

/* verif/fom_result_checker.sv */
// ============================================================================
// fom_result_checker
// Watches the input, config and result channels of the frame overrun monitor.
// Predicts each result word and compares it field by field.
// ============================================================================
`timescale 1ns / 1ps

module fom_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fom_in_if    in_ch,
    fom_out_if   out_ch,
    fom_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_owed_count
);
    import fom_pkg::*;

    // Predicted block state and registers
    t_fom_cfg         regs;
    logic [CYC_W-1:0] issued;
    logic [CYC_W-1:0] largest;
    logic [OVR_W-1:0] overruns;
    logic             lag_flag;
    logic             pause_flag;
    logic             stop_flag;
    logic             fail_flag;

    t_fom_out owed_results[$];
    t_fom_out owed_word;

    // One command through the monitor; updates the predicted state.
    function automatic t_fom_out monitor_step(input t_fom_in w);
        logic [CYC_W-1:0] lag;
        logic             busy;
        logic             viol;
        logic             tick;
        logic             loss;
        t_fom_out         r;
        tick = 1'b0;
        loss = 1'b0;
        viol = 1'b0;
        if (!stop_flag) begin
            if (w.command == CMD_TICK && !pause_flag) begin
                lag  = (issued > w.task_cycles) ? issued - w.task_cycles : '0;
                busy = w.step_unconsumed | w.pool_running;
                case (regs.rt_mode)
                    RT_HARD_TICK:   viol = busy;
                    RT_HARD_PERIOD: viol = w.period_miss;
                    RT_SOFT_LAG: begin
                        if (lag > {16'd0, regs.max_lag}) lag_flag = 1'b1;
                    end
                    default: ;
                endcase
                if (lag > largest && lag > 1) begin
                    largest = lag;
                    loss    = 1'b1;
                end
                if (busy && overruns != '1) overruns = overruns + 1'b1;
                if (viol) begin
                    fail_flag = 1'b1;
                    stop_flag = 1'b1;
                end else begin
                    tick   = 1'b1;
                    issued = issued + 1'b1;
                    if (regs.stop_on_cycle && issued >= regs.target_cycle)
                        stop_flag = 1'b1;
                    else if (w.pause_request)
                        pause_flag = 1'b1;
                end
            end else if (w.command == CMD_RESUME && pause_flag) begin
                pause_flag = 1'b0;
                overruns   = '0;
            end else if (w.command == CMD_STOP) begin
                stop_flag = 1'b1;
            end
        end
        r.tick_sent     = tick;
        r.cycle_count   = issued;
        r.hard_fail     = fail_flag;
        r.stopped       = stop_flag;
        r.paused        = pause_flag;
        r.lag_over      = lag_flag;
        r.lag_record    = loss;
        r.worst_lag     = largest;
        r.overrun_total = overruns;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CYC_W-1:0] want,
                               input logic [CYC_W-1:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs       = '0;
            issued     = '0;
            largest    = '0;
            overruns   = '0;
            lag_flag   = 1'b0;
            pause_flag = 1'b0;
            stop_flag  = 1'b0;
            fail_flag  = 1'b0;
            owed_results.delete();
        end else begin
            // Retire first: a result leaving now belongs to an older word.
            if (out_ch.valid && out_ch.ready) begin
                if (owed_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result word with none outstanding", $time);
                end else begin
                    owed_word = owed_results.pop_front();
                    check_field("tick_sent", owed_word.tick_sent, out_ch.data.tick_sent);
                    check_field("cycle_count", owed_word.cycle_count,
                                out_ch.data.cycle_count);
                    check_field("hard_fail", owed_word.hard_fail, out_ch.data.hard_fail);
                    check_field("stopped", owed_word.stopped, out_ch.data.stopped);
                    check_field("paused", owed_word.paused, out_ch.data.paused);
                    check_field("lag_over", owed_word.lag_over, out_ch.data.lag_over);
                    check_field("lag_record", owed_word.lag_record, out_ch.data.lag_record);
                    check_field("worst_lag", owed_word.worst_lag, out_ch.data.worst_lag);
                    check_field("overrun_total", owed_word.overrun_total,
                                out_ch.data.overrun_total);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_RT_MODE:       regs.rt_mode       = cfg_ch.wdata[2:0];
                    REG_MAX_LAG:       regs.max_lag       = cfg_ch.wdata[15:0];
                    REG_STOP_ON_CYCLE: regs.stop_on_cycle = cfg_ch.wdata[0];
                    REG_TARGET_CYCLE:  regs.target_cycle  = cfg_ch.wdata;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                owed_results.push_back(monitor_step(in_ch.data));
        end
        o_owed_count <= owed_results.size();
    end

endmodule

/* verif/frame_overrun_monitor_test.sv */
// ============================================================================
// frame_overrun_monitor_test
// Drives the frame overrun monitor with directed and random command words
// across a series of register settings; a side checker predicts every result.
// ============================================================================
`timescale 1ns / 1ps

module frame_overrun_monitor_test;
    import fom_pkg::*;

    // Generous: far above what the whole run needs, even when stalled.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 68;
    localparam int NUM_PHASES   = 9;

    // Encodings the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam logic [2:0] RT_RESERVED_LO = 3'd5;
    localparam logic [2:0] RT_RESERVED_HI = 3'd7;

    // Ways the run may end; stopping is permanent, so only one per run.
    typedef enum int {
        END_HARD_TICK,
        END_HARD_PERIOD,
        END_TARGET,
        END_REQUEST
    } t_ending;

    logic i_clk;
    logic i_rst_n;

    fom_in_if  in_ch ();
    fom_out_if out_ch ();
    fom_cfg_if cfg_ch ();

    int               fail_count;
    int               owed_count;
    int               sender_idle_pct;
    int               receiver_stall_pct;
    int               cycles;
    // Upper bound of ticks issued; keeps task_cycles near the real count
    logic [CYC_W-1:0] ticks_sent;
    t_fom_cfg         phase_plan [NUM_PHASES];

    frame_overrun_monitor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    fom_result_checker i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_owed_count (owed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_fom_in make_word(input logic [1:0] cmd, input logic sp,
                                          input logic pa, input logic pm,
                                          input logic [CYC_W-1:0] tc, input logic pr);
        t_fom_in w;
        w.command         = cmd;
        w.step_unconsumed = sp;
        w.pool_running    = pa;
        w.period_miss     = pm;
        w.task_cycles     = tc;
        w.pause_request   = pr;
        return w;
    endfunction

    // Random command word. allow_busy / allow_miss keep the hard modes alive.
    function automatic t_fom_in random_word(input bit allow_busy, input bit allow_miss);
        int               pick;
        int               sel;
        logic [1:0]       cmd;
        logic [CYC_W-1:0] tc;
        pick = $urandom_range(99);
        sel  = $urandom_range(9);
        if (pick < 72)      cmd = CMD_TICK;
        else if (pick < 88) cmd = CMD_RESUME;
        else                cmd = CMD_UNUSED;
        // Mostly close to the issued count: small lags, some from the future.
        if (sel == 0)      tc = '0;
        else if (sel == 1) tc = $urandom;
        else               tc = ticks_sent + 2 - $urandom_range(0, 8);
        return make_word(cmd,
                         allow_busy && ($urandom_range(99) < 30),
                         allow_busy && ($urandom_range(99) < 30),
                         allow_miss && ($urandom_range(99) < 30),
                         tc,
                         $urandom_range(99) < 12);
    endfunction

    task automatic set_idling(input int pattern);
        case (pattern % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
            default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
        endcase
    endtask

    // Leaves valid high on return; the next word or drain() takes it down.
    task automatic send_word(input t_fom_in w);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (w.command == CMD_TICK) ticks_sent++;
    endtask

    // Only called with the block idle; drops valid itself.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input t_fom_cfg c);
        write_reg(REG_RT_MODE, {29'd0, c.rt_mode});
        write_reg(REG_MAX_LAG, {16'd0, c.max_lag});
        write_reg(REG_STOP_ON_CYCLE, {31'd0, c.stop_on_cycle});
        write_reg(REG_TARGET_CYCLE, c.target_cycle);
    endtask

    // The owed count is registered and lags acceptance, hence the first step.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        t_ending ending;
        t_fom_cfg final_cfg;

        ticks_sent         = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.wdata <= '0;

        // Settings for the random part. Anything that can stop the block is
        // held back (stop is only undone by reset), so the hard modes run
        // with their violation input kept low and the target out of reach.
        phase_plan[0] = '{rt_mode: RT_SOFT_LAG, max_lag: 16'hFFFF,
                          stop_on_cycle: 1'b0, target_cycle: 32'd0};
        phase_plan[1] = '{rt_mode: RT_SKIP_BUSY, max_lag: 16'd0,
                          stop_on_cycle: 1'b1, target_cycle: 32'hFFFF_FFFF};
        phase_plan[2] = '{rt_mode: RT_LOG_ONLY, max_lag: 16'd5,
                          stop_on_cycle: 1'b0, target_cycle: 32'd0};
        phase_plan[3] = '{rt_mode: RT_RESERVED_LO, max_lag: 16'd0,
                          stop_on_cycle: 1'b0, target_cycle: 32'd1};
        phase_plan[4] = '{rt_mode: RT_RESERVED_HI, max_lag: 16'd0,
                          stop_on_cycle: 1'b1, target_cycle: 32'hFFFF_FFF0};
        phase_plan[5] = '{rt_mode: RT_HARD_PERIOD, max_lag: 16'd2,
                          stop_on_cycle: 1'b0, target_cycle: 32'd0};
        phase_plan[6] = '{rt_mode: RT_HARD_TICK, max_lag: 16'd2,
                          stop_on_cycle: 1'b0, target_cycle: 32'd0};
        phase_plan[7] = '{rt_mode: RT_SOFT_LAG, max_lag: 16'($urandom_range(1, 4)),
                          stop_on_cycle: 1'b0, target_cycle: 32'hFFFF_FFFF};
        phase_plan[8] = '{rt_mode: RT_SKIP_BUSY, max_lag: 16'hFFFF,
                          stop_on_cycle: 1'b1, target_cycle: 32'hFFFF_FFFF};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: log-only mode so nothing stops the block yet
        write_all('{rt_mode: RT_LOG_ONLY, max_lag: 16'hFFFF,
                    stop_on_cycle: 1'b0, target_cycle: 32'hFFFF_FFFF});
        send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
        send_word(make_word(CMD_TICK, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        send_word(make_word(CMD_TICK, 1'b0, 1'b1, 1'b0, 32'd1, 1'b0));
        send_word(make_word(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));  // lag 4
        send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));  // lag 5
        send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd1, 1'b0));  // no new max
        send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd7, 1'b0));  // lag 0
        // Resume with nothing paused, unused command
        send_word(make_word(CMD_RESUME, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(CMD_UNUSED, 1'b1, 1'b1, 1'b1, 32'd0, 1'b1));
        // Pause, ticks ignored while paused, then resume clears overruns
        send_word(make_word(CMD_TICK, 1'b1, 1'b0, 1'b0, 32'd8, 1'b1));
        send_word(make_word(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0));
        send_word(make_word(CMD_UNUSED, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
        send_word(make_word(CMD_RESUME, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
        send_word(make_word(CMD_TICK, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(CMD_RESUME, 1'b0, 1'b0, 1'b0, 32'hAAAA_5555, 1'b0));
        send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'h5555_AAAA, 1'b0));
        drain();

        // Random phases, each with its own settings and idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_all(phase_plan[p]);
            set_idling(p);
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_word(phase_plan[p].rt_mode != RT_HARD_TICK,
                                      phase_plan[p].rt_mode != RT_HARD_PERIOD));
            drain();
            set_idling(0);
        end

        // Ending: one stopping event, then words the stopped block must ignore
        ending    = t_ending'($urandom_range(3));
        final_cfg = '{rt_mode: RT_LOG_ONLY, max_lag: 16'd0,
                      stop_on_cycle: 1'b0, target_cycle: 32'hFFFF_FFFF};
        case (ending)
            END_HARD_TICK:   final_cfg.rt_mode = RT_HARD_TICK;
            END_HARD_PERIOD: final_cfg.rt_mode = RT_HARD_PERIOD;
            END_TARGET: begin
                final_cfg.stop_on_cycle = 1'b1;
                final_cfg.target_cycle  = 32'd1;
            end
            default: ;
        endcase
        write_all(final_cfg);
        set_idling(3);
        send_word(make_word(CMD_RESUME, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
        send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, ticks_sent, 1'b0));
        case (ending)
            END_HARD_TICK:
                send_word(make_word(CMD_TICK, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
            END_HARD_PERIOD:
                send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b1, 32'd0, 1'b0));
            END_TARGET:
                send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
            default: begin
                // Stop request while paused: the pause flag must survive it
                send_word(make_word(CMD_TICK, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1));
                send_word(make_word(CMD_STOP, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
            end
        endcase
        for (int n = 0; n < 10; n++)
            send_word(make_word(2'($urandom_range(3)), 1'($urandom), 1'($urandom),
                                1'($urandom), $urandom, 1'($urandom)));
        drain();

        if (fail_count == 0 && owed_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
